FILE: rtl/url_target_tokenizer_defines.svh
// Assertion macros used by the tokenizer parser RTL.
`ifndef URL_TARGET_TOKENIZER_DEFINES_SVH
`define URL_TARGET_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define UTT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer assertion failed");

`define UTT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer forbidden condition seen");

`else

`define UTT_ASSERT(lbl, clk, rst_n, prop)

`define UTT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: rtl/utt_pkg.sv
`timescale 1ns / 1ps

package utt_pkg;

    localparam logic [1:0] SEC_PATH  = 2'd0;
    localparam logic [1:0] SEC_NAME  = 2'd1;
    localparam logic [1:0] SEC_VALUE = 2'd2;

    localparam logic [1:0] ESC_IDLE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic       has_byte;
        logic [7:0] out_byte;
        logic       token_end;
        logic       no_value;
        logic       target_done;
        logic       error;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h57);
        end
        return h;
    endfunction

endpackage

FILE: rtl/utt_parser.sv
`timescale 1ns / 1ps
`include "url_target_tokenizer_defines.svh"

module utt_parser
    import utt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] ch,
    input  logic       end_mark,
    input  logic       out_free,
    output logic       go,
    output logic       res_valid,
    output result_t    res
);

    logic [1:0] section_reg, section_next;
    logic [1:0] escape_reg, escape_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       at_start_reg, at_start_next;
    logic       failed_reg, failed_next;

    logic [1:0] sec;
    hex_t       hex;
    logic [7:0] plain_byte;

    assign sec        = (section_reg > SEC_VALUE) ? SEC_VALUE : section_reg;
    assign hex        = hex_decode(ch);
    assign plain_byte = (ch == CH_PLUS) ? CH_SPACE : ch;

    always_comb
    begin
        section_next  = section_reg;
        escape_next   = escape_reg;
        nibble_next   = nibble_reg;
        at_start_next = at_start_reg;
        failed_next   = failed_reg;
        res_valid     = 1'b0;
        res           = '0;
        if (end_mark)
        begin
            res_valid = 1'b1;
            res.target_done = 1'b1;
            if (failed_reg || escape_reg != ESC_IDLE)
            begin
                res.error = 1'b1;
            end
            else
            begin
                res.kind      = sec;
                res.token_end = 1'b1;
                res.no_value  = (sec == SEC_NAME);
            end
            section_next  = SEC_PATH;
            escape_next   = ESC_IDLE;
            nibble_next   = '0;
            at_start_next = 1'b1;
            failed_next   = 1'b0;
        end
        else if (!failed_reg)
        begin
            at_start_next = 1'b0;
            if (!(at_start_reg && ch == CH_SLASH))
            begin
                if (escape_reg != ESC_IDLE)
                begin
                    if (!hex.ok)
                    begin
                        failed_next = 1'b1;
                        escape_next = ESC_IDLE;
                    end
                    else if (escape_reg == ESC_FIRST)
                    begin
                        nibble_next = hex.value;
                        escape_next = ESC_SECOND;
                    end
                    else
                    begin
                        escape_next  = ESC_IDLE;
                        res_valid    = 1'b1;
                        res.kind     = sec;
                        res.has_byte = 1'b1;
                        res.out_byte = {nibble_reg, hex.value};
                    end
                end
                else if (ch == CH_PERCENT)
                begin
                    escape_next = ESC_FIRST;
                end
                else
                begin
                    res_valid = 1'b1;
                    res.kind  = sec;
                    case (sec)
                        SEC_PATH:
                        begin
                            if (ch == CH_SLASH || ch == CH_QUEST)
                            begin
                                res.token_end = 1'b1;
                                if (ch == CH_QUEST)
                                begin
                                    section_next = SEC_NAME;
                                end
                            end
                            else
                            begin
                                res.has_byte = 1'b1;
                                res.out_byte = ch;
                            end
                        end
                        SEC_NAME:
                        begin
                            if (ch == CH_EQUAL)
                            begin
                                res.token_end = 1'b1;
                                section_next  = SEC_VALUE;
                            end
                            else if (ch == CH_AMP)
                            begin
                                res.token_end = 1'b1;
                                res.no_value  = 1'b1;
                            end
                            else
                            begin
                                res.has_byte = 1'b1;
                                res.out_byte = plain_byte;
                            end
                        end
                        default:
                        begin
                            if (ch == CH_AMP)
                            begin
                                res.token_end = 1'b1;
                                section_next  = SEC_NAME;
                            end
                            else
                            begin
                                res.has_byte = 1'b1;
                                res.out_byte = plain_byte;
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign go = in_valid && (out_free || !res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg  <= SEC_PATH;
            escape_reg   <= ESC_IDLE;
            nibble_reg   <= '0;
            at_start_reg <= 1'b1;
            failed_reg   <= 1'b0;
        end
        else if (go)
        begin
            section_reg  <= section_next;
            escape_reg   <= escape_next;
            nibble_reg   <= nibble_next;
            at_start_reg <= at_start_next;
            failed_reg   <= failed_next;
        end
    end

    `UTT_ASSERT(a_end_section, clk, rst_n, (go && end_mark) |=> (section_reg == SEC_PATH))
    `UTT_ASSERT(a_end_escape, clk, rst_n, (go && end_mark) |=> (escape_reg == ESC_IDLE))
    `UTT_ASSERT(a_end_flags, clk, rst_n, (go && end_mark) |=> (at_start_reg && !failed_reg))
    `UTT_NEVER(a_byte_and_end, clk, rst_n, res_valid && res.has_byte && res.token_end)
    `UTT_NEVER(a_failed_silent, clk, rst_n, in_valid && failed_reg && !end_mark && res_valid)
    `UTT_ASSERT(a_error_is_done, clk, rst_n, (res_valid && res.error) |-> res.target_done)

endmodule

FILE: rtl/url_target_tokenizer.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_ready  | ch, end_mark
// output   | out_valid / out_ready| kind, has_byte, out_byte, token_end, no_value,
//          |                      | target_done, error
//
// One request is accepted per clock unless the output stalls; results can leave
// back to back. Requests pass the input register, then the result register.
// The rate is set by the single decode step between input and result registers.
// Reset (rst_n low) empties both registers and starts a new target.
// A stalled output holds its result; the input register still takes one request.

module url_target_tokenizer
    import utt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       end_mark,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic       has_byte,
    output logic [7:0] out_byte,
    output logic       token_end,
    output logic       no_value,
    output logic       target_done,
    output logic       error
);

    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] ch_reg;
    logic       end_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg;

    logic       go;
    logic       res_valid;
    result_t    res;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !stage_valid_reg || go;

    utt_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid_reg),
        .ch        (ch_reg),
        .end_mark  (end_reg),
        .out_free  (out_free),
        .go        (go),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (go)
        begin
            stage_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (go && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= ch;
            end_reg <= end_mark;
        end
        if (go && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = result_reg.kind;
    assign has_byte    = result_reg.has_byte;
    assign out_byte    = result_reg.out_byte;
    assign token_end   = result_reg.token_end;
    assign no_value    = result_reg.no_value;
    assign target_done = result_reg.target_done;
    assign error       = result_reg.error;

endmodule
